FILE: src/lmsd_pkg.sv
// shared types, constants and helpers for the led matrix scan driver
// no dependencies; imported by led_matrix_spi_scan_driver
package lmsd_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int IDX_W       = $clog2(MATRIX_SIZE);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ROW_W       = 8;
    localparam int LIT_W       = 4;
    localparam int LIT_LEVELS  = ROW_W + 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [LIT_W-1:0] lit_t;

    localparam logic [1:0] CMD_SPI_BYTE = 2'd0;
    localparam logic [1:0] CMD_SS_RISE  = 2'd1;
    localparam logic [1:0] CMD_REFRESH  = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam row_t ROW_ALL_OFF = '1;

    // on-time compare value, indexed by the number of lit rows
    localparam logic [7:0] ON_TIME_TABLE [0:LIT_LEVELS-1] = '{
        8'd255, 8'd48, 8'd77, 8'd107, 8'd136, 8'd166, 8'd195, 8'd225, 8'd255
    };

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] shift_out_byte;
        logic       drive_valid;
        logic [2:0] column_select;
        logic [7:0] row_bits;
        logic [7:0] on_time;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_COPY,
        ST_ROW,
        ST_EMIT
    } state_t;

    // (a + b) mod MATRIX_SIZE for a, b already below MATRIX_SIZE
    function automatic idx_t wrap_add(idx_t a, idx_t b);
        cnt_t s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CNT_W'(MATRIX_SIZE)) begin
            s = s - CNT_W'(MATRIX_SIZE);
        end
        return s[IDX_W-1:0];
    endfunction

    // lit rows are the low bits of the active-low pattern
    function automatic lit_t lit_count(row_t row);
        lit_t n;
        n = '0;
        for (int i = 0; i < ROW_W; i++) begin
            n = n + {{(LIT_W-1){1'b0}}, ~row[i]};
        end
        return n;
    endfunction

endpackage

FILE: src/led_matrix_spi_scan_driver.sv
// led matrix scan driver: spi shift ring, frame latch copy and column scan
// ring and frame store are memories with registered reads; depends on lmsd_pkg
// path to the output register: slave select or unused command via the emit state, spi byte
// via shift, refresh tick via row, refresh tick with latch copy via the copy sweep and row
// a new transfer is taken only in idle, once the last has left emit; the copy sweep reads
// the ring through its single read port, one byte per cycle
// reset (aresetn low, synchronous) clears control state and the per-entry valid bits;
// ring entries read as 0x00 and frame entries as 0xff until written
module led_matrix_spi_scan_driver (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lmsd_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lmsd_pkg::out_item_t m_data
);
    import lmsd_pkg::*;

    state_t    state_reg, state_next;
    idx_t      idx_reg, idx_next;
    idx_t      col_reg, col_next;
    logic      armed_reg, armed_next;
    cnt_t      cnt_reg, cnt_next;
    out_item_t res_reg, res_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // memories and their valid bits
    logic [7:0] ring_mem  [0:MATRIX_SIZE-1];
    row_t       frame_mem [0:MATRIX_SIZE-1];
    logic [MATRIX_SIZE-1:0] ring_vld_reg;
    logic [MATRIX_SIZE-1:0] frame_vld_reg;
    logic [7:0] ring_rd_reg;
    logic       ring_rd_vld_reg;
    row_t       frame_rd_reg;
    logic       frame_rd_vld_reg;

    logic       ring_we, ring_re;
    idx_t       ring_waddr, ring_raddr;
    logic [7:0] ring_wdata;
    logic       frame_we, frame_re;
    idx_t       frame_waddr, frame_raddr;
    row_t       frame_wdata;

    logic       accept;
    logic       out_free;
    logic       copy_go;
    logic [7:0] ring_byte;
    row_t       row;
    lit_t       lit;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign copy_go   = (col_reg == '0) && armed_reg;
    assign ring_byte = ring_rd_vld_reg ? ring_rd_reg : 8'h00;
    assign row       = frame_rd_vld_reg ? frame_rd_reg : ROW_ALL_OFF;
    assign lit       = lit_count(row);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.command)
                        CMD_SPI_BYTE: state_next = ST_SHIFT;
                        CMD_REFRESH:  state_next = copy_go ? ST_COPY : ST_ROW;
                        CMD_SS_RISE,
                        CMD_UNUSED:   state_next = ST_EMIT;
                        default:      state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SHIFT: state_next = ST_EMIT;
            ST_COPY: begin
                if (cnt_reg == CNT_W'(MATRIX_SIZE)) begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        idx_next     = idx_reg;
        col_next     = col_reg;
        armed_next   = armed_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ring_we      = 1'b0;
        ring_waddr   = idx_reg;
        ring_wdata   = s_data.data_byte;
        ring_re      = 1'b0;
        ring_raddr   = wrap_add(idx_reg, IDX_W'(1));
        frame_we     = 1'b0;
        frame_waddr  = cnt_reg[IDX_W-1:0] - IDX_W'(1);
        frame_wdata  = ~ring_byte;
        frame_re     = 1'b0;
        frame_raddr  = col_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    unique case (s_data.command)
                        CMD_SPI_BYTE: begin
                            ring_we  = 1'b1;
                            ring_re  = 1'b1;
                            idx_next = wrap_add(idx_reg, IDX_W'(1));
                        end
                        CMD_SS_RISE: armed_next = 1'b1;
                        CMD_REFRESH: begin
                            col_next = wrap_add(col_reg, IDX_W'(1));
                            cnt_next = '0;
                            if (copy_go) begin
                                armed_next = 1'b0;
                            end else begin
                                frame_re    = 1'b1;
                                frame_raddr = col_next;
                            end
                        end
                        CMD_UNUSED: ;
                        default: ;
                    endcase
                end
            end
            ST_SHIFT: res_next.shift_out_byte = ring_byte;
            ST_COPY: begin
                // read ring oldest-first, write the inverted byte in the following cycle
                if (cnt_reg != CNT_W'(MATRIX_SIZE)) begin
                    ring_re    = 1'b1;
                    ring_raddr = wrap_add(cnt_reg[IDX_W-1:0], idx_reg);
                end else begin
                    frame_re = 1'b1;
                end
                if (cnt_reg != '0) begin
                    frame_we = 1'b1;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_ROW: begin
                res_next.drive_valid   = 1'b1;
                res_next.column_select = 3'(col_reg);
                res_next.row_bits      = row;
                res_next.on_time       = ON_TIME_TABLE[lit];
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            col_reg       <= '0;
            armed_reg     <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            ring_vld_reg  <= '0;
            frame_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            col_reg     <= col_next;
            armed_reg   <= armed_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (ring_we) begin
                ring_vld_reg[ring_waddr] <= 1'b1;
            end
            if (frame_we) begin
                frame_vld_reg[frame_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // shift ring memory
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re) begin
            ring_rd_reg     <= ring_mem[ring_raddr];
            ring_rd_vld_reg <= ring_vld_reg[ring_raddr];
        end
    end

    // frame store memory, last copy write forwarded to a same-entry read
    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            if (frame_we && (frame_waddr == frame_raddr)) begin
                frame_rd_reg     <= frame_wdata;
                frame_rd_vld_reg <= 1'b1;
            end else begin
                frame_rd_reg     <= frame_mem[frame_raddr];
                frame_rd_vld_reg <= frame_vld_reg[frame_raddr];
            end
        end
    end

`ifndef ASSERT_OFF
    a_copy_clears_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == CMD_REFRESH && copy_go)
            |=> (!armed_reg && state_reg == ST_COPY && cnt_reg == '0))
        else $error("latch copy did not start cleanly");

    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (cnt_reg <= CNT_W'(MATRIX_SIZE)))
        else $error("copy sweep overran the ring");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg < IDX_W'(MATRIX_SIZE - 1) || idx_reg == IDX_W'(MATRIX_SIZE - 1))
            && (col_reg < IDX_W'(MATRIX_SIZE - 1) || col_reg == IDX_W'(MATRIX_SIZE - 1)))
        else $error("ring or column index out of range");

    a_drive_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.drive_valid)
            |-> (m_data_reg.row_bits == '0 && m_data_reg.on_time == '0
                 && m_data_reg.column_select == '0))
        else $error("drive fields set without a column drive");
`endif

endmodule
